// ===== rtl/arsp_pkg.sv =====
package arsp_pkg;

  localparam int CaptureDepth = 262144;
  localparam int MeterSteps = 16;
  localparam int SampleBits = 24;
  localparam logic [63:0] TenthPowQ32 = 64'd270994116;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_ENTER = 3'd1,
    OP_KEY = 3'd2,
    OP_CANCEL = 3'd3,
    OP_COMMIT = 3'd4,
    OP_READ = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STANDBY = 3'd1,
    M_ARMED = 3'd2,
    M_REC = 3'd3,
    M_REVIEW = 3'd4,
    M_DONE = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    R_INPUT_GAIN = 3'd0,
    R_TRIGGER = 3'd1,
    R_AUTO = 3'd2,
    R_RELEASE = 3'd3,
    R_CAPACITY = 3'd4,
    R_STEREO = 3'd5,
    R_SLOTS = 3'd6
  } reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_EXEC,
    S_DIV,
    S_PROG,
    S_READ,
    S_SCALE,
    S_OUT
  } state_t;

  // Threshold r^(j+1) in Q0.32, where r is the largest ratio whose MeterSteps-th
  // power stays at or below -24 dB. Only evaluated at elaboration.
  function automatic logic [31:0] meter_thr(input int j);
    logic [63:0] lo, hi, mid, p, t;
    begin
      lo = '0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        p = mid;
        for (int i = 1; i < MeterSteps; i++) p = (p * mid) >> 32;
        if (p <= TenthPowQ32) lo = mid;
        else hi = mid - 64'd1;
      end
      t = lo;
      for (int i = 0; i < j; i++) t = (t * lo) >> 32;
      return t[31:0];
    end
  endfunction

endpackage

// ===== rtl/auto_record_sampler_with_peak_meter_unit.sv =====
// Sampler controller with a peak meter. An item passes from its transfer to
// its result through the gain, execute, scale, progress and output states,
// with the progress state repeated for each progress step shown; a read also
// passes a read state before scaling. Finishing a recording replaces the scale
// state with a bit-serial reciprocal. The next item is taken the cycle after the
// result transfer. The capture memory has one write and one registered read port.
module auto_record_sampler_with_peak_meter_unit import arsp_pkg::*; #(
  parameter int CAPTURE_DEPTH = CaptureDepth,
  parameter int SAMPLE_BITS = SampleBits
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [22:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             op,
  input  logic [SAMPLE_BITS-1:0] left_sample,
  input  logic [SAMPLE_BITS-1:0] right_sample,
  input  logic                   right_present,
  input  logic [7:0]             slot,
  input  logic [17:0]            read_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             mode,
  output logic [4:0]             meter_steps,
  output logic [4:0]             progress_steps,
  output logic [18:0]            captured_length,
  output logic                   commit_ok,
  output logic [SAMPLE_BITS-1:0] read_left,
  output logic [SAMPLE_BITS-1:0] read_right
);

  localparam int METER_STEPS = MeterSteps;
  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(CAPTURE_DEPTH);
  localparam int CNW = AW + 1;
  localparam logic [SB-2:0] SMAX = '1;

  logic [15:0] input_gain;
  logic [22:0] trigger_level;
  logic auto_record_on;
  logic [15:0] meter_release;
  logic [18:0] capture_capacity;
  logic stereo_mode;
  logic [7:0] slot_count;

  state_t state, state_next;
  mode_t smode;
  logic [SB-2:0] meter_peak;
  logic [CNW-1:0] capture_count;
  logic [SB-2:0] capture_peak;
  logic [31:0] normalise_gain;

  logic [2:0] op_q;
  logic [SB-1:0] ls_q, rs_q;
  logic [7:0] slot_q;
  logic [17:0] ridx_q;

  logic signed [SB-1:0] gl, gr;
  logic [SB-2:0] al, ar;
  logic ok_q;
  logic [SB-1:0] rl_q, rr_q;
  logic rd_ok;
  logic [CNW-1:0] cap_eff;
  logic [4:0] prog_q;

  logic wr_en;
  logic [2*SB-1:0] wr_data, rd_data;
  logic div_start, div_busy;
  logic [31:0] div_q;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain <= 16'd4096;
      trigger_level <= '0;
      auto_record_on <= 1'b0;
      meter_release <= 16'd65470;
      capture_capacity <= 19'd262144;
      stereo_mode <= 1'b1;
      slot_count <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_t'(cfg_index))
        R_INPUT_GAIN: input_gain <= cfg_data[15:0];
        R_TRIGGER: trigger_level <= cfg_data;
        R_AUTO: auto_record_on <= cfg_data[0];
        R_RELEASE: meter_release <= cfg_data[15:0];
        R_CAPACITY: capture_capacity <= cfg_data[18:0];
        R_STEREO: begin
          if (smode != M_REC && smode != M_REVIEW) begin
            stereo_mode <= cfg_data[0];
          end
        end
        R_SLOTS: slot_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (capture_capacity == '0) begin
      cap_eff = CNW'(1);
    end else if (32'(capture_capacity) > 32'(CAPTURE_DEPTH)) begin
      cap_eff = CNW'(CAPTURE_DEPTH);
    end else begin
      cap_eff = CNW'(capture_capacity);
    end
  end

  function automatic logic [SB-1:0] sat_scale(input logic [SB-1:0] v,
                                               input logic [31:0] mul,
                                               input int sh);
    logic neg;
    logic [SB-1:0] m;
    logic [SB+31:0] q;
    begin
      neg = v[SB-1];
      m = neg ? -v : v;
      q = ((SB+32)'(m) * (SB+32)'(mul) + ((SB+32)'(1) << (sh - 1))) >> sh;
      if (neg) begin
        if (q > (SB+32)'(SMAX) + 1) q = (SB+32)'(SMAX) + 1;
        return -q[SB-1:0];
      end
      if (q > (SB+32)'(SMAX)) q = (SB+32)'(SMAX);
      return q[SB-1:0];
    end
  endfunction

  function automatic logic [SB-2:0] mag(input logic [SB-1:0] v);
    logic [SB-1:0] m;
    begin
      m = v[SB-1] ? -v : v;
      return m[SB-1] ? SMAX : m[SB-2:0];
    end
  endfunction

  logic [SB-1:0] mono;
  logic [SB:0] msum;
  logic [SB-2:0] am;
  logic [SB-2:0] lvl;
  logic [SB+15:0] decay;

  always_comb begin
    msum = {gl[SB-1], gl} + {gr[SB-1], gr};
    mono = msum[SB:1] + SB'(msum[SB] & msum[0]);
    am = mag(mono);
    lvl = al > ar ? al : ar;
    decay = (SB+16)'(meter_peak) * (SB+16)'(meter_release);
  end

  assign wr_en = (state == S_EXEC) && (op_t'(op_q) == OP_SAMPLE) &&
                 (smode == M_REC ||
                  (smode == M_ARMED && 32'(lvl) >= 32'(trigger_level))) &&
                 !(smode == M_REC && capture_count >= CNW'(CAPTURE_DEPTH));
  assign wr_data = stereo_mode ? {gl, gr} : {mono, SB'(0)};

  arsp_store #(.DEPTH(CAPTURE_DEPTH), .WIDTH(2 * SB)) u_store (
    .clk(clk), .wr_en(wr_en),
    .wr_addr((smode == M_ARMED) ? AW'(0) : capture_count[AW-1:0]),
    .wr_data(wr_data), .rd_addr(AW'(ridx_q)), .rd_data(rd_data));

  logic [SB-2:0] peak_new;
  logic need_finish;
  logic fin;

  always_comb begin
    peak_new = (smode == M_ARMED) ? '0 : capture_peak;
    if (stereo_mode) begin
      if (al > peak_new) peak_new = al;
      if (ar > peak_new) peak_new = ar;
    end else if (am > peak_new) begin
      peak_new = am;
    end
  end

  always_comb begin
    fin = 1'b0;
    case (op_t'(op_q))
      OP_SAMPLE: begin
        if (wr_en) begin
          if (smode == M_ARMED) fin = CNW'(1) >= cap_eff;
          else fin = (capture_count + CNW'(1)) >= cap_eff;
        end else if (smode == M_REC) begin
          fin = 1'b1;
        end
      end
      OP_KEY: fin = (smode == M_REC);
      default: ;
    endcase
  end

  assign div_start = need_finish && state == S_DIV;

  arsp_div #(.SB(SB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .peak(capture_peak),
    .busy(div_busy), .quot(div_q));

  logic [CNW+5:0] pq;
  logic [4:0] msteps;
  logic [31:0] pq32;
  logic [METER_STEPS-1:0] lit;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && !in_stall) state_next = S_GAIN;
      S_GAIN: state_next = S_EXEC;
      S_EXEC: begin
        if (fin) state_next = S_DIV;
        else if (op_t'(op_q) == OP_READ) state_next = S_READ;
        else state_next = S_SCALE;
      end
      S_DIV: if (!div_busy && !div_start) state_next = S_PROG;
      S_READ: state_next = S_SCALE;
      S_SCALE: state_next = S_PROG;
      S_PROG: if (pq == '0 || prog_q >= 5'(METER_STEPS)) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      smode <= M_IDLE;
      meter_peak <= '0;
      capture_count <= '0;
      capture_peak <= '0;
      normalise_gain <= 32'h0100_0000;
      out_valid <= 1'b0;
      need_finish <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_q <= op;
            ls_q <= left_sample;
            rs_q <= right_present ? right_sample : left_sample;
            slot_q <= slot;
            ridx_q <= read_index;
          end
        end
        S_GAIN: begin
          gl <= sat_scale(ls_q, 32'(input_gain), 12);
          gr <= sat_scale(rs_q, 32'(input_gain), 12);
          al <= mag(sat_scale(ls_q, 32'(input_gain), 12));
          ar <= mag(sat_scale(rs_q, 32'(input_gain), 12));
          ok_q <= 1'b0;
          rd_ok <= 1'b0;
        end
        S_EXEC: begin
          need_finish <= fin;
          case (op_t'(op_q))
            OP_SAMPLE: begin
              if (smode != M_IDLE) begin
                meter_peak <= lvl > meter_peak ? lvl : decay[SB+14:16];
                if (wr_en) begin
                  capture_peak <= peak_new;
                  if (smode == M_ARMED) begin
                    smode <= M_REC;
                    normalise_gain <= 32'h0100_0000;
                    capture_count <= CNW'(1);
                  end else begin
                    capture_count <= capture_count + CNW'(1);
                  end
                end
              end
            end
            OP_ENTER, OP_CANCEL: begin
              smode <= (op_t'(op_q) == OP_ENTER) ? M_STANDBY : M_IDLE;
              meter_peak <= '0;
              capture_count <= '0;
              capture_peak <= '0;
              normalise_gain <= 32'h0100_0000;
            end
            OP_KEY: begin
              if ((smode == M_STANDBY && !auto_record_on) || smode == M_ARMED) begin
                smode <= M_REC;
                capture_count <= '0;
                capture_peak <= '0;
                normalise_gain <= 32'h0100_0000;
              end else if (smode == M_STANDBY) begin
                smode <= M_ARMED;
              end
            end
            OP_COMMIT: begin
              if (smode == M_REVIEW && capture_count != '0 && slot_q < slot_count) begin
                smode <= M_DONE;
                ok_q <= 1'b1;
              end
            end
            OP_READ: begin
              rd_ok <= (smode == M_REVIEW || smode == M_DONE) &&
                       (CNW'(ridx_q) < capture_count);
            end
            default: ;
          endcase
        end
        S_DIV: begin
          need_finish <= 1'b0;
          if (!div_busy && !div_start) begin
            smode <= M_REVIEW;
            if ((64'(capture_peak) * 64'd1000000) > (64'd1 << (SB - 1))) begin
              normalise_gain <= div_q;
            end else begin
              normalise_gain <= 32'h0100_0000;
            end
          end
        end
        S_SCALE: begin
          rl_q <= rd_ok ? sat_scale(rd_data[2*SB-1:SB], normalise_gain, 24) : '0;
          rr_q <= (rd_ok && stereo_mode) ?
                  sat_scale(rd_data[SB-1:0], normalise_gain, 24) : '0;
        end
        S_OUT: begin
          mode <= smode;
          captured_length <= 19'(capture_count);
          commit_ok <= ok_q;
          read_left <= (op_t'(op_q) == OP_READ) ? rl_q : '0;
          read_right <= (op_t'(op_q) == OP_READ) ? rr_q : '0;
          progress_steps <= (capture_count == '0) ? 5'd0 :
                            (prog_q > 5'(METER_STEPS) ? 5'(METER_STEPS) : prog_q);
          meter_steps <= msteps;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Progress by repeated subtraction: ceil(count*M/cap), at most M+1 steps.
  always_ff @(posedge clk) begin
    if (state != S_PROG) begin
      pq <= (CNW+6)'(capture_count) * (CNW+6)'(METER_STEPS);
      prog_q <= '0;
    end else if (pq != '0) begin
      pq <= (pq > (CNW+6)'(cap_eff)) ? pq - (CNW+6)'(cap_eff) : '0;
      prog_q <= prog_q + 5'd1;
    end
  end

  for (genvar j = 0; j < METER_STEPS; j++) begin : g_thr
    localparam logic [31:0] THR = meter_thr(j);
    assign lit[j] = pq32 > THR;
  end

  always_comb begin
    pq32 = 32'(meter_peak) << (33 - SB);
    msteps = '0;
    if (meter_peak != '0) begin
      for (int j = 0; j < METER_STEPS; j++) msteps = msteps + 5'(lit[j]);
    end
  end

  assert property (@(posedge clk) disable iff (rst) wr_en |-> state == S_EXEC);
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode)) else $error("out held");
  assert property (@(posedge clk) disable iff (rst)
    capture_count <= CNW'(CAPTURE_DEPTH)) else $error("count range");
  assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy) else $error("div start");

endmodule

// ===== rtl/arsp_store.sv =====
module arsp_store import arsp_pkg::*; #(
  parameter int DEPTH = CaptureDepth,
  parameter int WIDTH = 2 * SampleBits
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/arsp_div.sv =====
module arsp_div import arsp_pkg::*; #(
  parameter int SB = SampleBits
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SB-2:0] peak,
  output logic          busy,
  output logic [31:0]   quot
);

  localparam int NW = SB + 24;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [SB:0] rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic [SB:0] trial;

  assign trial = {rem[SB-1:0], num[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      num <= (NW'(1) << (SB + 23)) + NW'(peak >> 1);
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (trial >= (SB+1)'(peak)) begin
        rem <= trial - (SB+1)'(peak);
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = (q >> 32) != '0 ? 32'hFFFFFFFF : q[31:0];

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import arsp_pkg::*;

  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;
  localparam longint SMax = 64'd8388607;
  localparam longint SSign = 64'd8388608;
  localparam longint GainOne = 64'd16777216;
  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 120;

  typedef struct {
    logic [2:0] op;
    logic [23:0] l;
    logic [23:0] r;
    logic rp;
    logic [7:0] slot;
    logic [17:0] idx;
    bit typed;
    mode_t e_mode;
    logic e_ok;
  } stim_t;

  typedef struct {
    logic [2:0] mode;
    logic [4:0] meter;
    logic [4:0] prog;
    logic [18:0] len;
    logic ok;
    logic [23:0] rl;
    logic [23:0] rr;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] op = '0;
  logic [23:0] left_sample = '0;
  logic [23:0] right_sample = '0;
  logic right_present = 0;
  logic [7:0] slot = '0;
  logic [17:0] read_index = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] mode;
  logic [4:0] meter_steps;
  logic [4:0] progress_steps;
  logic [18:0] captured_length;
  logic commit_ok;
  logic [23:0] read_left;
  logic [23:0] read_right;

  auto_record_sampler_with_peak_meter_unit i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Sampler shadow state.
  longint gain_cfg, trig_cfg, auto_cfg, release_cfg, cap_cfg, stereo_cfg, slots_cfg;
  mode_t sh_mode;
  longint sh_meter, sh_count, sh_peak, sh_norm;
  longint cap_left[int];
  longint cap_right[int];
  longint thr[16];

  result_t pending_results[$];
  stim_t directed[$];
  int errors = 0;
  int sent = 0;
  bit gaps_on = 1;
  bit long_hold = 0;

  function automatic longint sext24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint mag_cap(longint v);
    longint m;
    m = v < 0 ? -v : v;
    return m > SMax ? SMax : m;
  endfunction

  function automatic longint gain_round(longint v, longint unsigned mul, int sh);
    longint unsigned m, q;
    m = v < 0 ? -v : v;
    q = (m * mul + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) return q > SSign ? -SSign : -longint'(q);
    return q > SMax ? SMax : longint'(q);
  endfunction

  function automatic longint unsigned pow_q32(longint unsigned r, int n);
    longint unsigned p;
    p = r;
    for (int i = 1; i < n; i++) p = (p * r) >> 32;
    return p;
  endfunction

  function automatic longint eff_capacity();
    if (cap_cfg < 1) return 1;
    if (cap_cfg > CaptureDepth) return CaptureDepth;
    return cap_cfg;
  endfunction

  function automatic void clear_take();
    sh_count = 0;
    sh_peak = 0;
    sh_norm = GainOne;
  endfunction

  function automatic void close_take();
    longint g;
    if (sh_peak * 1000000 <= SSign) begin
      sh_norm = GainOne;
    end else begin
      g = ((64'd1 << 47) + sh_peak / 2) / sh_peak;
      sh_norm = g > 64'hFFFFFFFF ? 64'hFFFFFFFF : g;
    end
    sh_mode = M_REVIEW;
  endfunction

  function automatic void open_take();
    clear_take();
    sh_mode = M_REC;
  endfunction

  function automatic void sample_in(stim_t s);
    longint ls, rs, l, r, al, ar, lvl, m;
    if (sh_mode == M_IDLE) return;
    ls = sext24(s.l);
    rs = s.rp ? sext24(s.r) : ls;
    l = gain_round(ls, gain_cfg, 12);
    r = gain_round(rs, gain_cfg, 12);
    al = mag_cap(l);
    ar = mag_cap(r);
    lvl = al > ar ? al : ar;
    sh_meter = lvl > sh_meter ? lvl : (sh_meter * release_cfg) >> 16;
    if (sh_mode == M_ARMED && lvl >= trig_cfg) open_take();
    if (sh_mode != M_REC) return;
    if (sh_count >= CaptureDepth) begin
      close_take();
      return;
    end
    if (stereo_cfg != 0) begin
      cap_left[sh_count] = l;
      cap_right[sh_count] = r;
      if (al > sh_peak) sh_peak = al;
      if (ar > sh_peak) sh_peak = ar;
    end else begin
      m = (l + r) / 2;
      cap_left[sh_count] = m;
      cap_right[sh_count] = 0;
      if (mag_cap(m) > sh_peak) sh_peak = mag_cap(m);
    end
    sh_count++;
    if (sh_count >= eff_capacity()) close_take();
  endfunction

  function automatic result_t sampler_step(stim_t s);
    result_t e;
    longint rl, rr, lit, p, cap;
    e.ok = 0;
    rl = 0;
    rr = 0;
    case (s.op)
      OP_SAMPLE: sample_in(s);
      OP_ENTER: begin
        sh_mode = M_STANDBY;
        sh_meter = 0;
        clear_take();
      end
      OP_KEY: begin
        if (sh_mode == M_STANDBY) begin
          if (auto_cfg != 0) sh_mode = M_ARMED;
          else open_take();
        end else if (sh_mode == M_ARMED) begin
          open_take();
        end else if (sh_mode == M_REC) begin
          close_take();
        end
      end
      OP_CANCEL: begin
        sh_mode = M_IDLE;
        sh_meter = 0;
        clear_take();
      end
      OP_COMMIT: begin
        if (sh_mode == M_REVIEW && sh_count > 0 && s.slot < slots_cfg) begin
          sh_mode = M_DONE;
          e.ok = 1;
        end
      end
      OP_READ: begin
        if ((sh_mode == M_REVIEW || sh_mode == M_DONE) && s.idx < sh_count) begin
          rl = gain_round(cap_left[s.idx], sh_norm, 24);
          if (stereo_cfg != 0) rr = gain_round(cap_right[s.idx], sh_norm, 24);
        end
      end
      default: ;
    endcase
    lit = 0;
    if (sh_meter != 0) begin
      p = sh_meter << 9;
      for (int j = 0; j < 16; j++) if (p > thr[j]) lit++;
    end
    e.prog = 0;
    if (sh_count > 0) begin
      cap = eff_capacity();
      e.prog = ((sh_count * 16 + cap - 1) / cap) > 16 ? 16 : (sh_count * 16 + cap - 1) / cap;
    end
    e.mode = sh_mode;
    e.meter = lit;
    e.len = sh_count;
    e.rl = rl[23:0];
    e.rr = rr[23:0];
    return e;
  endfunction

  task automatic send(stim_t s);
    int gap;
    result_t e;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    op <= s.op;
    left_sample <= s.l;
    right_sample <= s.r;
    right_present <= s.rp;
    slot <= s.slot;
    read_index <= s.idx;
    do @(posedge clk); while (in_stall);
    e = sampler_step(s);
    if (s.typed) begin
      e.mode = s.e_mode;
      e.ok = s.e_ok;
    end
    pending_results = {pending_results, e};
    sent++;
  endtask

  task automatic write_reg(reg_t idx, longint value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value[22:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      R_INPUT_GAIN: gain_cfg = value & 16'hFFFF;
      R_TRIGGER: trig_cfg = value & 23'h7FFFFF;
      R_AUTO: auto_cfg = value & 1;
      R_RELEASE: release_cfg = value & 16'hFFFF;
      R_CAPACITY: cap_cfg = value & 19'h7FFFF;
      R_STEREO: if (sh_mode != M_REC && sh_mode != M_REVIEW) stereo_cfg = value & 1;
      R_SLOTS: slots_cfg = value & 8'hFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic longint pick(longint lo, longint hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endcase
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 6))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 16)) - 8);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic stim_t mk(logic [2:0] o);
    stim_t s;
    s.op = o;
    s.l = rand_sample();
    s.r = rand_sample();
    s.rp = $urandom_range(0, 1);
    s.slot = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20));
    if (sh_count > 0 && $urandom_range(0, 4) != 0)
      s.idx = $urandom_range(0, 32'(sh_count - 1));
    else
      s.idx = 18'($urandom);
    s.typed = 0;
    s.e_mode = M_IDLE;
    s.e_ok = 0;
    return s;
  endfunction

  task automatic row(logic [2:0] o, logic [23:0] l, logic [23:0] r, logic rp, logic [7:0] sl,
                     logic [17:0] ix, bit typed, mode_t em, logic eok);
    stim_t s;
    s = '{o, l, r, rp, sl, ix, typed, em, eok};
    directed = {directed, s};
  endtask

  // A recording session with random content, interleaved with stray operations.
  task automatic session();
    int n;
    send(mk(OP_ENTER));
    send(mk(OP_KEY));
    n = $urandom_range(1, 45);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 12) == 0) send(mk(3'($urandom_range(0, 7))));
      else send(mk(OP_SAMPLE));
    end
    if ($urandom_range(0, 2) != 0) send(mk(OP_KEY));
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) send(mk(OP_READ));
    send(mk(OP_COMMIT));
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) send(mk($urandom_range(0, 1) ? OP_READ : OP_COMMIT));
    if ($urandom_range(0, 3) == 0) send(mk(OP_CANCEL));
  endtask

  // Receiver side.
  initial begin
    int n;
    result_t e;
    @(negedge rst);
    forever begin
      n = long_hold ? 400 : (gaps_on ? $urandom_range(0, 4) : 0);
      long_hold = 0;
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("unexpected transfer on result channel");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (mode !== e.mode) begin
          $error("mode exp %0d got %0d", e.mode, mode); errors++;
        end
        if (meter_steps !== e.meter) begin
          $error("meter_steps exp %0d got %0d", e.meter, meter_steps); errors++;
        end
        if (progress_steps !== e.prog) begin
          $error("progress_steps exp %0d got %0d", e.prog, progress_steps); errors++;
        end
        if (captured_length !== e.len) begin
          $error("captured_length exp %0d got %0d", e.len, captured_length); errors++;
        end
        if (commit_ok !== e.ok) begin
          $error("commit_ok exp %0d got %0d", e.ok, commit_ok); errors++;
        end
        if (read_left !== e.rl) begin
          $error("read_left exp %h got %h", e.rl, read_left); errors++;
        end
        if (read_right !== e.rr) begin
          $error("read_right exp %h got %h", e.rr, read_right); errors++;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= WatchLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'hFFFFFFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (pow_q32(mid, 16) <= 64'd270994116) lo = mid;
      else hi = mid - 1;
    end
    thr[0] = lo;
    for (int j = 1; j < 16; j++) thr[j] = (longint'(thr[j - 1]) * lo) >> 32;
    gain_cfg = 4096; trig_cfg = 0; auto_cfg = 0; release_cfg = 65470;
    cap_cfg = 262144; stereo_cfg = 1; slots_cfg = 16;
    sh_mode = M_IDLE; sh_meter = 0;
    clear_take();

    row(OP_SAMPLE, 24'h7FFFFF, 0, 1, 0, 0, 1, M_IDLE, 0);
    row(OP_KEY, 0, 0, 0, 0, 0, 1, M_IDLE, 0);
    row(OP_COMMIT, 0, 0, 0, 0, 0, 1, M_IDLE, 0);
    row(OP_READ, 0, 0, 0, 0, 0, 1, M_IDLE, 0);
    row(OpSpare6, 24'hFFFFFF, 24'hFFFFFF, 1, 8'hFF, 18'h3FFFF, 1, M_IDLE, 0);
    row(OP_ENTER, 0, 0, 0, 0, 0, 1, M_STANDBY, 0);
    row(OpSpare7, 0, 0, 0, 0, 0, 1, M_STANDBY, 0);
    row(OP_SAMPLE, 24'h7FFFFF, 24'h000000, 1, 0, 0, 1, M_STANDBY, 0);
    row(OP_SAMPLE, 24'h800000, 24'h000000, 0, 0, 0, 1, M_STANDBY, 0);
    row(OP_KEY, 0, 0, 0, 0, 0, 1, M_REC, 0);
    row(OP_SAMPLE, 24'h7FFFFF, 24'h800000, 1, 0, 0, 0, M_IDLE, 0);
    row(OP_SAMPLE, 24'h000003, 24'hFFFFFD, 1, 0, 0, 0, M_IDLE, 0);
    row(OP_SAMPLE, 24'h123456, 24'h000000, 0, 0, 0, 0, M_IDLE, 0);
    row(OP_KEY, 0, 0, 0, 0, 0, 1, M_REVIEW, 0);
    row(OP_READ, 0, 0, 0, 0, 0, 0, M_IDLE, 0);
    row(OP_READ, 0, 0, 0, 0, 1, 0, M_IDLE, 0);
    row(OP_READ, 0, 0, 0, 0, 18'h3FFFF, 1, M_REVIEW, 0);
    row(OP_COMMIT, 0, 0, 0, 16, 0, 1, M_REVIEW, 0);
    row(OP_COMMIT, 0, 0, 0, 8'hFF, 0, 1, M_REVIEW, 0);
    row(OP_COMMIT, 0, 0, 0, 0, 0, 1, M_DONE, 1);
    row(OP_READ, 0, 0, 0, 0, 2, 0, M_IDLE, 0);
    row(OP_CANCEL, 0, 0, 0, 0, 0, 1, M_IDLE, 0);
    row(OP_ENTER, 0, 0, 0, 0, 0, 1, M_STANDBY, 0);
    row(OP_KEY, 0, 0, 0, 0, 0, 1, M_REC, 0);
    row(OP_SAMPLE, 24'h000001, 24'h000000, 0, 0, 0, 0, M_IDLE, 0);

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int ph = 0; ph < 14 && sent < 1025; ph++) begin
      write_reg(R_INPUT_GAIN, ph == 0 ? 0 : ph == 1 ? 65535 : pick(0, 65535));
      write_reg(R_TRIGGER, ph == 2 ? 0 : ph == 3 ? 8388607 : pick(0, 8388607));
      write_reg(R_AUTO, ph % 2);
      write_reg(R_RELEASE, ph == 4 ? 0 : ph == 5 ? 65535 : pick(0, 65535));
      case ($urandom_range(0, 7))
        0: write_reg(R_CAPACITY, 0);
        1: write_reg(R_CAPACITY, ph > 10 ? 524287 : 1);
        2: write_reg(R_CAPACITY, 262144);
        default: write_reg(R_CAPACITY, $urandom_range(2, 40));
      endcase
      write_reg(R_STEREO, $urandom_range(0, 1));
      write_reg(R_SLOTS, ph == 6 ? 0 : ph == 7 ? 255 : pick(0, 255));
      gaps_on = (ph % 4) != 3;
      if (ph == 5) long_hold = 1;
      while (sent < 80 * (ph + 1) + 25) begin
        if ($urandom_range(0, 5) == 0) send(mk(3'($urandom_range(0, 7))));
        else session();
        if (ph == 8 && sent > 80 * ph + 60) begin
          in_valid <= 0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== auto_record_sampler_with_peak_meter_unit.f =====
rtl/arsp_pkg.sv
rtl/arsp_store.sv
rtl/arsp_div.sv
rtl/auto_record_sampler_with_peak_meter_unit.sv
dv/tb_top.sv
